FILE: hw/rtl/depth_pixel_to_point_macros.svh
// Assertion macros for the depth pixel to point block
`ifndef DEPTH_PIXEL_TO_POINT_MACROS_SVH
`define DEPTH_PIXEL_TO_POINT_MACROS_SVH

`ifndef SYNTHESIS

`define DPP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpp assertion failed");

`define DPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpp assertion failed");

`else

`define DPP_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define DPP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/dpp_pkg.sv
// Shared types and constants for the depth pixel to point block
`default_nettype none

package dpp_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W   = 12;
    localparam int LIM_W   = 14;
    localparam int DEPTH_W = 16;
    localparam int COLOR_W = 8;
    localparam int INV_W   = 24;
    localparam int CTR_W   = 16;
    localparam int COORD_W = 26;
    localparam int DIFF_W  = 17;
    localparam int MAG_W   = 16;
    localparam int P1_W    = MAG_W + DEPTH_W;
    localparam int P2_W    = P1_W + INV_W;
    localparam int RND_SH  = 20;
    localparam int Q_W     = P2_W + 1 - RND_SH;
    localparam int STAGES  = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [INV_W-1:0] INV_FOCAL_X_RST = 24'd31457;
    localparam logic [INV_W-1:0] INV_FOCAL_Y_RST = 24'd31457;
    localparam logic [CTR_W-1:0] CENTER_X_RST    = 16'd15360;
    localparam logic [CTR_W-1:0] CENTER_Y_RST    = 16'd8640;

    localparam logic [Q_W-1:0] COORD_POS_LIM = Q_W'((64'd1 << (COORD_W - 1)) - 64'd1);
    localparam logic [Q_W-1:0] COORD_NEG_LIM = Q_W'(64'd1 << (COORD_W - 1));
    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_FOCAL_X = 3'd0,
        REG_INV_FOCAL_Y = 3'd1,
        REG_CENTER_X    = 3'd2,
        REG_CENTER_Y    = 3'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [INV_W-1:0] inv_focal_x;
        logic [INV_W-1:0] inv_focal_y;
        logic [CTR_W-1:0] center_x;
        logic [CTR_W-1:0] center_y;
    } cfg_t;

    typedef struct packed {
        logic [STAGES-1:0] ld;
    } adv_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dpp_cfg.sv
// Configuration register file for the depth pixel to point block
`default_nettype none

module dpp_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [dpp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dpp_pkg::CFG_DATA_W-1:0]  cfg_data,
    output dpp_pkg::cfg_t                        cfg
);

    dpp_pkg::cfg_t cfg_reg;
    dpp_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                dpp_pkg::REG_INV_FOCAL_X:
                    cfg_next.inv_focal_x = cfg_data[dpp_pkg::INV_W-1:0];
                dpp_pkg::REG_INV_FOCAL_Y:
                    cfg_next.inv_focal_y = cfg_data[dpp_pkg::INV_W-1:0];
                dpp_pkg::REG_CENTER_X:
                    cfg_next.center_x = cfg_data[dpp_pkg::CTR_W-1:0];
                dpp_pkg::REG_CENTER_Y:
                    cfg_next.center_y = cfg_data[dpp_pkg::CTR_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_focal_x <= dpp_pkg::INV_FOCAL_X_RST;
            cfg_reg.inv_focal_y <= dpp_pkg::INV_FOCAL_Y_RST;
            cfg_reg.center_x    <= dpp_pkg::CENTER_X_RST;
            cfg_reg.center_y    <= dpp_pkg::CENTER_Y_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/dpp_axis.sv
// Four-stage projection pipeline for one coordinate axis
`default_nettype none

module dpp_axis (
    input  wire logic                               clk,
    input  wire dpp_pkg::adv_t                      adv,
    input  wire logic [dpp_pkg::PIX_W-1:0]          pix,
    input  wire logic [dpp_pkg::DEPTH_W-1:0]        depth,
    input  wire logic [dpp_pkg::CTR_W-1:0]          center,
    input  wire logic [dpp_pkg::INV_W-1:0]          inv_focal,
    input  wire logic                               ok_s3,
    output logic signed [dpp_pkg::COORD_W-1:0]      coord
);

    logic signed [dpp_pkg::DIFF_W-1:0] diff;
    logic signed [dpp_pkg::DIFF_W-1:0] diff_abs;
    logic                              neg1_reg;
    logic [dpp_pkg::MAG_W-1:0]         mag1_reg;
    logic [dpp_pkg::DEPTH_W-1:0]       dep1_reg;
    logic                              neg2_reg;
    logic [dpp_pkg::P1_W-1:0]          p1_reg;
    logic                              neg3_reg;
    logic [dpp_pkg::P2_W-1:0]          p2_reg;
    logic [dpp_pkg::P2_W:0]            rnd;
    logic [dpp_pkg::Q_W-1:0]           q;
    logic [dpp_pkg::COORD_W-1:0]       coord_next;
    logic [dpp_pkg::COORD_W-1:0]       coord_reg;

    // signed offset from principal point in 1/16 pixel
    assign diff     = $signed({1'b0, pix, 4'b0000}) - $signed({1'b0, center});
    assign diff_abs = diff[dpp_pkg::DIFF_W-1] ? -diff : diff;

    assign rnd = {1'b0, p2_reg} + ((dpp_pkg::P2_W+1)'(1) << (dpp_pkg::RND_SH - 1));
    assign q   = rnd[dpp_pkg::P2_W:dpp_pkg::RND_SH];

    always_comb
    begin
        if (!ok_s3)
            coord_next = '0;
        else if (neg3_reg)
        begin
            if (q > dpp_pkg::COORD_NEG_LIM)
                coord_next = dpp_pkg::COORD_MIN;
            else
                coord_next = ~q[dpp_pkg::COORD_W-1:0] + dpp_pkg::COORD_W'(1);
        end
        else
        begin
            if (q > dpp_pkg::COORD_POS_LIM)
                coord_next = dpp_pkg::COORD_MAX;
            else
                coord_next = q[dpp_pkg::COORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.ld[0])
        begin
            neg1_reg <= diff[dpp_pkg::DIFF_W-1];
            mag1_reg <= diff_abs[dpp_pkg::MAG_W-1:0];
            dep1_reg <= depth;
        end
        if (adv.ld[1])
        begin
            neg2_reg <= neg1_reg;
            p1_reg   <= dpp_pkg::P1_W'(mag1_reg) * dpp_pkg::P1_W'(dep1_reg);
        end
        if (adv.ld[2])
        begin
            neg3_reg <= neg2_reg;
            p2_reg   <= dpp_pkg::P2_W'(p1_reg) * dpp_pkg::P2_W'(inv_focal);
        end
        if (adv.ld[3])
        begin
            coord_reg <= coord_next;
        end
    end

    assign coord = $signed(coord_reg);

endmodule

`default_nettype wire

FILE: hw/rtl/depth_pixel_to_point.sv
// Top level of the depth pixel to point back-projection block
// An accepted word passes through the stage registers to its result word on the output.
// Throughput: one word per cycle; each stage holds while the next one is full and stalled.
// Timing is set by the 32 x 24 bit multiply in the third stage of each axis.
// Reset: rst_n clears all stage valid bits and loads the default camera intrinsics.
`default_nettype none

`include "depth_pixel_to_point_macros.svh"

module depth_pixel_to_point (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [dpp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [dpp_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [dpp_pkg::PIX_W-1:0]             pixel_column,
    input  wire logic [dpp_pkg::PIX_W-1:0]             pixel_row,
    input  wire logic [dpp_pkg::DEPTH_W-1:0]           depth_mm,
    input  wire logic [dpp_pkg::COLOR_W-1:0]           in_blue,
    input  wire logic [dpp_pkg::COLOR_W-1:0]           in_green,
    input  wire logic [dpp_pkg::COLOR_W-1:0]           in_red,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [dpp_pkg::COORD_W-1:0]         point_x,
    output logic signed [dpp_pkg::COORD_W-1:0]         point_y,
    output logic [dpp_pkg::DEPTH_W-1:0]                point_z,
    output logic                                       point_valid,
    output logic [dpp_pkg::COLOR_W-1:0]                out_blue,
    output logic [dpp_pkg::COLOR_W-1:0]                out_green,
    output logic [dpp_pkg::COLOR_W-1:0]                out_red
);

    localparam int S = dpp_pkg::STAGES;

    dpp_pkg::cfg_t cfg;
    dpp_pkg::adv_t adv;

    logic [S-1:0] vld_reg;
    logic [S-1:0] vld_next;
    logic [S-1:0] ready;
    logic         ok_in;

    logic                           ok_pipe_reg    [S];
    logic [dpp_pkg::DEPTH_W-1:0]    depth_pipe_reg [S];
    logic [dpp_pkg::COLOR_W-1:0]    blue_pipe_reg  [S];
    logic [dpp_pkg::COLOR_W-1:0]    green_pipe_reg [S];
    logic [dpp_pkg::COLOR_W-1:0]    red_pipe_reg   [S];

    dpp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // a stage takes a new word when it is empty or its word moves on
    always_comb
    begin
        ready[S-1] = !vld_reg[S-1] || !out_stall;
        for (int k = S - 2; k >= 0; k--)
        begin
            ready[k] = !vld_reg[k] || ready[k+1];
        end
        adv.ld = ready;
        vld_next[0] = ready[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < S; k++)
        begin
            vld_next[k] = ready[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    assign in_stall = !ready[0];

    assign ok_in = (depth_mm != '0)
                && (dpp_pkg::LIM_W'(pixel_column) < dpp_pkg::LIM_W'(dpp_pkg::MAX_WIDTH))
                && (dpp_pkg::LIM_W'(pixel_row) < dpp_pkg::LIM_W'(dpp_pkg::MAX_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv.ld[0])
        begin
            ok_pipe_reg[0]    <= ok_in;
            depth_pipe_reg[0] <= ok_in ? depth_mm : '0;
            blue_pipe_reg[0]  <= ok_in ? in_blue  : '0;
            green_pipe_reg[0] <= ok_in ? in_green : '0;
            red_pipe_reg[0]   <= ok_in ? in_red   : '0;
        end
        for (int k = 1; k < S; k++)
        begin
            if (adv.ld[k])
            begin
                ok_pipe_reg[k]    <= ok_pipe_reg[k-1];
                depth_pipe_reg[k] <= depth_pipe_reg[k-1];
                blue_pipe_reg[k]  <= blue_pipe_reg[k-1];
                green_pipe_reg[k] <= green_pipe_reg[k-1];
                red_pipe_reg[k]   <= red_pipe_reg[k-1];
            end
        end
    end

    dpp_axis u_axis_x (
        .clk       (clk),
        .adv       (adv),
        .pix       (pixel_column),
        .depth     (depth_mm),
        .center    (cfg.center_x),
        .inv_focal (cfg.inv_focal_x),
        .ok_s3     (ok_pipe_reg[S-2]),
        .coord     (point_x)
    );

    dpp_axis u_axis_y (
        .clk       (clk),
        .adv       (adv),
        .pix       (pixel_row),
        .depth     (depth_mm),
        .center    (cfg.center_y),
        .inv_focal (cfg.inv_focal_y),
        .ok_s3     (ok_pipe_reg[S-2]),
        .coord     (point_y)
    );

    assign out_valid   = vld_reg[S-1];
    assign point_valid = ok_pipe_reg[S-1];
    assign point_z     = depth_pipe_reg[S-1];
    assign out_blue    = blue_pipe_reg[S-1];
    assign out_green   = green_pipe_reg[S-1];
    assign out_red     = red_pipe_reg[S-1];

    `DPP_ASSERT_IMPL(a_bad_point_zero, clk, rst_n, out_valid && !point_valid, point_x == '0 && point_y == '0 && point_z == '0 && out_red == '0)
    `DPP_ASSERT_IMPL(a_good_point_depth, clk, rst_n, out_valid && point_valid, point_z != '0)
    `DPP_ASSERT_IMPL(a_stall_only_full, clk, rst_n, in_stall, vld_reg == '1 && out_stall)
    `DPP_ASSERT_NEXT(a_held_output, clk, rst_n, out_valid && out_stall, out_valid && point_z == $past(point_z))

endmodule

`default_nettype wire
